// ===== design/sha256_message_padder_macros.svh =====
// Assertion macros shared by the checker of the SHA-256 message padder.
// No dependencies; include with the bare file name.
`ifndef SHA256_MESSAGE_PADDER_MACROS_SVH
`define SHA256_MESSAGE_PADDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("padder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("padder check failed");

`endif

// ===== design/sha_pad_pkg.sv =====
// Shared types and constants of the SHA-256 message padder.
// No dependencies; imported by the front end, the queue and the back end.
package sha_pad_pkg;

  // Message byte counter width (lengths wrap modulo 2^61 bytes).
  localparam int unsigned TotalW = 61;
  localparam int unsigned BitLenW = 64;

  // Padding constants.
  localparam logic [7:0] PadMarker = 8'h80;
  // Final byte offsets up to this one leave room for the length in the same block.
  localparam logic [5:0] LastOneBlockOfs = 6'd54;
  // Offset of the first length byte, counted from the start of the first padded block.
  localparam logic [6:0] LenStartOne = 7'd56;
  localparam logic [6:0] LenStartTwo = 7'd120;
  // Index of the final word, counted the same way.
  localparam logic [4:0] LastWordOne = 5'd15;
  localparam logic [4:0] LastWordTwo = 5'd31;
  // Byte offset of the last byte of a block's first word.
  localparam logic [5:0] FirstWordEndOfs = 6'd3;

  // Queue depth between front end and back end.
  localparam int unsigned QueueDepth = 2;

  // One queued job: a finished message word, or the tail of a message to pad.
  typedef struct packed {
    logic               is_final;     // 1: tail job, back end appends the padding
    logic [31:0]        word;         // packed bytes; for a tail, lanes up to the final byte
    logic               block_first;  // data word at offset 0 of a block
    logic [5:0]         offset;       // block offset of the final byte
    logic [BitLenW-1:0] bit_len;      // message length in bits
  } sp_entry_t;

endpackage

// ===== design/sha_pad_front.sv =====
// Front end of the SHA-256 message padder: packs bytes into words and counts length.
// Depends on sha_pad_pkg.
module sha_pad_front
  import sha_pad_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic      final_byte_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output sp_entry_t q_entry_o
);

  logic [TotalW-1:0] byte_total_q, byte_total_d;
  logic [23:0]       partial_q, partial_d;
  logic [TotalW-1:0] pos_next;
  logic [1:0]        lane;
  logic [31:0]       word;
  logic              accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign lane       = byte_total_q[1:0];
  assign pos_next   = byte_total_q + TotalW'(1);

  // Merge the incoming byte into its lane; upper lanes are still zero.
  always_comb begin
    word = {8'h00, partial_q};
    word[{lane, 3'b000} +: 8] = data_byte_i;
  end

  // Build the queue entry for a completed word or a message tail.
  always_comb begin
    q_entry_o.is_final    = final_byte_i;
    q_entry_o.word        = word;
    q_entry_o.block_first = (byte_total_q[5:0] == FirstWordEndOfs);
    q_entry_o.offset      = byte_total_q[5:0];
    q_entry_o.bit_len     = {pos_next, 3'b000};
    q_push_o              = accept && (final_byte_i || (lane == 2'd3));
  end

  // Next message state.
  always_comb begin
    byte_total_d = byte_total_q;
    partial_d    = partial_q;
    if (accept) begin
      if (final_byte_i) begin
        byte_total_d = '0;
        partial_d    = '0;
      end else begin
        byte_total_d = pos_next;
        partial_d    = (lane == 2'd3) ? 24'h000000 : word[23:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_total_q <= '0;
      partial_q    <= '0;
    end else begin
      byte_total_q <= byte_total_d;
      partial_q    <= partial_d;
    end
  end

endmodule

// ===== design/sha_pad_fifo.sv =====
// Short job queue between the front end and the back end of the padder.
// Depends on sha_pad_pkg.
module sha_pad_fifo
  import sha_pad_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sp_entry_t push_entry_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      head_valid_o,
  output sp_entry_t head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  sp_entry_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o       = (count_q == CntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill-level updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== design/sha_pad_back.sv =====
// Back end of the padder: emits queued words and generates the padding words.
// Depends on sha_pad_pkg.
module sha_pad_back
  import sha_pad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  sp_entry_t   head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] padded_word_o,
  output logic        block_first_o,
  output logic        message_done_o,
  output logic        run_last_o
);

  logic        started_q, started_d;
  logic [4:0]  widx_q, widx_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] word_q;
  logic        first_q, done_q, rlast_q;
  logic [4:0]  cur_widx;
  logic [4:0]  last_widx;
  logic        last_word;
  logic        load;
  logic [31:0] pad_word;

  // One word of the padded tail, byte by byte from its block offset.
  function automatic logic [31:0] tail_word(input logic [4:0] widx, input sp_entry_t e);
    logic [6:0]  ofs;
    logic [6:0]  fin;
    logic [6:0]  len_start;
    logic [6:0]  rel;
    logic [2:0]  idx;
    logic [31:0] w;
    fin       = {1'b0, e.offset};
    len_start = (e.offset <= LastOneBlockOfs) ? LenStartOne : LenStartTwo;
    w         = '0;
    for (int l = 0; l < 4; l++) begin
      ofs = {widx, 2'(l)};
      rel = ofs - len_start;
      idx = 3'd7 - rel[2:0];
      if (ofs <= fin) begin
        w[8*l +: 8] = e.word[8*l +: 8];
      end else if (ofs == fin + 7'd1) begin
        w[8*l +: 8] = PadMarker;
      end else if (ofs >= len_start) begin
        w[8*l +: 8] = e.bit_len[{idx, 3'b000} +: 8];
      end else begin
        w[8*l +: 8] = 8'h00;
      end
    end
    return w;
  endfunction

  // Word position inside the job and its end.
  assign cur_widx  = started_q ? widx_q : {1'b0, head_i.offset[5:2]};
  assign last_widx = (head_i.offset <= LastOneBlockOfs) ? LastWordOne : LastWordTwo;
  assign last_word = !head_i.is_final || (cur_widx == last_widx);
  assign load      = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o     = load && last_word;
  assign pad_word  = tail_word(cur_widx, head_i);

  // Job sequencing and output register occupancy.
  always_comb begin
    started_d   = started_q;
    widx_d      = widx_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (last_word) begin
        started_d = 1'b0;
      end else begin
        started_d = 1'b1;
        widx_d    = cur_widx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (head_i.is_final) begin
        word_q  <= pad_word;
        first_q <= (cur_widx[3:0] == 4'd0);
        done_q  <= last_word;
        rlast_q <= last_word;
      end else begin
        word_q  <= head_i.word;
        first_q <= head_i.block_first;
        done_q  <= 1'b0;
        rlast_q <= 1'b1;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign padded_word_o  = word_q;
  assign block_first_o  = first_q;
  assign message_done_o = done_q;
  assign run_last_o     = rlast_q;

endmodule

// ===== design/sha256_message_padder.sv =====
// SHA-256 message padder: byte stream in, padded 32-bit word stream out.
// Depends on sha_pad_pkg, sha_pad_front, sha_pad_fifo and sha_pad_back.
//
// Usage:
//   The slave channel takes one message byte per beat; tlast marks the
//   final byte of a message. The master channel gives 32-bit words with the
//   earliest byte in bits 7:0; tlast marks the final word of the padded
//   message, tuser[0] the first word of a 64-byte block and tuser[1] the
//   last word caused by one input byte.
//   A word passes the job queue and the output register before it leaves.
//   Throughput: one byte per cycle while the queue has room. The final
//   byte of a message causes 3 to 19 words, produced one per cycle by the
//   back-end padding sequencer while the receiver takes them; the front end
//   keeps taking the next message's bytes until the two-entry queue fills.
//   Reset clears the byte count, the partial word, the queue and the
//   output valid flag. When the receiver stalls, the output word holds and
//   the queue fills, after which s_axis_tready_o drops.
module sha256_message_padder
  import sha_pad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] padded_word
  output logic [1:0]  m_axis_tuser_o,   // [0] block_first, [1] run_last
  output logic        m_axis_tlast_o
);

  sp_entry_t push_entry;
  sp_entry_t head;
  logic      push, full, pop, head_valid;
  logic      block_first, run_last;

  // Byte packing and length counting.
  sha_pad_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .data_byte_i  (s_axis_tdata_i),
    .final_byte_i (s_axis_tlast_i),
    .q_full_i     (full),
    .q_push_o     (push),
    .q_entry_o    (push_entry)
  );

  // Job queue.
  sha_pad_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Word output and padding generation.
  sha_pad_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .padded_word_o  (m_axis_tdata_o),
    .block_first_o  (block_first),
    .message_done_o (m_axis_tlast_o),
    .run_last_o     (run_last)
  );

  assign m_axis_tuser_o = {run_last, block_first};

endmodule

// ===== design/sha_pad_checker.sv =====
// Port-level checker of the SHA-256 message padder, bound to the top level.
// Depends on sha256_message_padder_macros.svh.
`include "sha256_message_padder_macros.svh"

module sha_pad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A stalled output beat keeps its word.
  `SP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // The final word of a message is always the last word of its run.
  `SP_ASSERT_NOW(a_done_is_run_last, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tuser_o[1])

  // The final word ends a block, so it is never a block's first word.
  `SP_ASSERT_NOW(a_done_not_first, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], !m_axis_tlast_o)

  // The bit length is a multiple of eight, so its low three bits are zero.
  `SP_ASSERT_NOW(a_len_byte_aligned, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tdata_o[26:24] == 3'b000)

endmodule

bind sha256_message_padder sha_pad_checker u_checker (.*);
